@@ sv/wave_pkg.sv @@
// Shared types and constants for the wheel angle velocity estimator.
package wave_pkg;

  localparam int ANGLE_FIELD_W = 10;
  localparam int TIME_W        = 32;
  localparam int VEL_W         = 32;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 40;
  localparam int PROD_W        = 52;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    logic [ANGLE_FIELD_W-1:0] angle;
    logic [TIME_W-1:0]        now;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } back_state_t;

endpackage

@@ sv/wheel_angle_velocity_estimator.sv @@
// Top level of the wheel angle velocity estimator.
//
// Input stream (s_*): each word is either an angle sample (tuser = 0) or a
// velocity query (tuser = 1). A sample adds the shortest signed angle step to
// a saturating 32-bit turn sum and produces no output. A query divides the
// turn sum, scaled to units per second, by the microseconds since the last
// query, clears the sum and emits one output word with the velocity and a
// status code (0 ok, 1 saturated, 2 zero elapsed time).
// Configuration (cfg_*): a one-bit direction_inverted register, always ready;
// it is to be written while the block is idle, which the block does not enforce.
// Sequence: a sample is handled in the accept state alone. A query passes
// through accept, multiply, 52 restoring divide steps at one quotient bit a
// cycle, final scaling and output, and waits in the output state while the
// output register is full. A zero elapsed time skips the multiply and the
// divider and goes from accept straight to output.
// A four-entry queue between the input and the execution unit absorbs words
// during a division. When the receiver stalls, the result is held in the
// output register; samples keep being processed, and a second query waits
// for that register to drain. Reset clears the turn sum, the last angle, the
// last query time, the queue and the output valid flag.
module wheel_angle_velocity_estimator #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [9:0] angle_sample, [41:10] now_us, [47:42] zero
  input  logic [wave_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] action
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] velocity, [33:32] status, [39:34] zero
  output logic [wave_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);

  logic            direction_inverted;
  logic            q_valid;
  logic            q_ready;
  wave_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_inverted <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction_inverted <= cfg_data;
    end
  end

  wave_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  wave_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .direction_inverted (direction_inverted),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_item             (q_item),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata)
  );

  // The execution unit must never take a word from an empty queue.
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> q_valid)
    else $error("queue popped while empty");

  // A result is never shown in the cycle after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Consuming a sample with an empty output register never creates a result.
  a_sample_no_result: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_item.kind == wave_pkg::KIND_SAMPLE && !m_tvalid)
    |=> !m_tvalid)
    else $error("result produced by an angle sample");

endmodule

@@ sv/wave_front.sv @@
// Input side: accepts words, classifies them and queues them for the back end.
module wave_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wave_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           q_valid,
  input  logic                           q_ready,
  output wave_pkg::item_t                q_item
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  wave_pkg::item_t      entries [QDepth];
  wave_pkg::item_t      in_item;
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [PtrW:0]        count;
  logic                 push;
  logic                 pop;

  always_comb begin
    in_item.kind  = s_tuser ? wave_pkg::KIND_QUERY : wave_pkg::KIND_SAMPLE;
    in_item.angle = s_tdata[wave_pkg::ANGLE_FIELD_W-1:0];
    in_item.now   = s_tdata[wave_pkg::ANGLE_FIELD_W +: wave_pkg::TIME_W];
  end

  assign s_tready = (count != (PtrW+1)'(QDepth));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign push     = s_tvalid & s_tready;
  assign pop      = q_valid & q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

@@ sv/wave_back.sv @@
// Execution side: turn sum accumulation, velocity division and result register.
module wave_back #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            direction_inverted,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  wave_pkg::item_t                 q_item,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wave_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int ExtW     = (ANGLE_BITS > wave_pkg::ANGLE_FIELD_W) ?
                            ANGLE_BITS : wave_pkg::ANGLE_FIELD_W;
  localparam int StepW    = ANGLE_BITS + 2;
  localparam int FullTurn = 1 << ANGLE_BITS;
  localparam int CntW     = $clog2(wave_pkg::PROD_W);
  localparam logic signed [StepW-1:0] FullS = StepW'(FullTurn);
  localparam logic signed [StepW-1:0] HalfS = StepW'(FullTurn / 2);

  wave_pkg::back_state_t state, state_next;

  logic [ANGLE_BITS-1:0]             last_angle;
  logic signed [wave_pkg::VEL_W-1:0] turn_sum;
  logic [wave_pkg::TIME_W-1:0]       last_query_time;

  logic                              neg;
  logic [wave_pkg::VEL_W-1:0]        mag;
  logic [wave_pkg::TIME_W-1:0]       elapsed;
  logic [wave_pkg::PROD_W-1:0]       quo;
  logic [wave_pkg::TIME_W-1:0]       rem;
  logic [CntW-1:0]                   cnt;
  logic signed [wave_pkg::VEL_W-1:0] res_vel;
  wave_pkg::status_t                 res_status;

  logic signed [wave_pkg::VEL_W-1:0] out_vel;
  wave_pkg::status_t                 out_status;
  logic                              out_valid;

  logic [ExtW-1:0]                   sample_ext;
  logic [ANGLE_BITS-1:0]             sample;
  logic signed [StepW-1:0]           d;
  logic signed [StepW-1:0]           step;
  logic signed [wave_pkg::VEL_W+1:0] sum_wide;
  logic signed [wave_pkg::VEL_W-1:0] sum_sat;
  logic [wave_pkg::TIME_W-1:0]       elapsed_c;
  logic [wave_pkg::TIME_W:0]         trial;
  logic                              trial_ge;
  logic                              out_free;
  logic                              start;

  // Angle step and saturating accumulate for a sample word.
  always_comb begin
    sample_ext = ExtW'(q_item.angle);
    sample     = sample_ext[ANGLE_BITS-1:0];
    d          = $signed({2'b00, sample}) - $signed({2'b00, last_angle});
    if (d > HalfS) begin
      step = FullS - d;
    end else if (d < -HalfS) begin
      step = -FullS - d;
    end else begin
      step = -d;
    end
    sum_wide = {{2{turn_sum[wave_pkg::VEL_W-1]}}, turn_sum}
             + {{(wave_pkg::VEL_W+2-StepW){step[StepW-1]}}, step};
    if (sum_wide[wave_pkg::VEL_W+1:wave_pkg::VEL_W-1] == 3'b000 ||
        sum_wide[wave_pkg::VEL_W+1:wave_pkg::VEL_W-1] == 3'b111) begin
      sum_sat = sum_wide[wave_pkg::VEL_W-1:0];
    end else if (sum_wide[wave_pkg::VEL_W+1]) begin
      sum_sat = wave_pkg::VEL_MIN;
    end else begin
      sum_sat = wave_pkg::VEL_MAX;
    end
    elapsed_c = q_item.now - last_query_time;
  end

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem, quo[wave_pkg::PROD_W-1]};
    trial_ge = (trial >= {1'b0, elapsed});
  end

  assign out_free = !out_valid || m_tready;
  assign start    = (state == wave_pkg::BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wave_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      wave_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_item.kind == wave_pkg::KIND_QUERY) begin
          state_next = (elapsed_c == '0) ? wave_pkg::BK_OUT : wave_pkg::BK_MUL;
        end
      end
      wave_pkg::BK_MUL: state_next = wave_pkg::BK_DIV;
      wave_pkg::BK_DIV: begin
        if (cnt == CntW'(wave_pkg::PROD_W - 1)) state_next = wave_pkg::BK_FIN;
      end
      wave_pkg::BK_FIN: state_next = wave_pkg::BK_OUT;
      wave_pkg::BK_OUT: begin
        if (out_free) state_next = wave_pkg::BK_IDLE;
      end
      default: state_next = wave_pkg::BK_IDLE;
    endcase
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle      <= '0;
      turn_sum        <= '0;
      last_query_time <= '0;
    end else if (start) begin
      if (q_item.kind == wave_pkg::KIND_SAMPLE) begin
        last_angle <= sample;
        turn_sum   <= sum_sat;
      end else begin
        turn_sum        <= '0;
        last_query_time <= q_item.now;
      end
    end
  end

  // Division datapath and result staging.
  always_ff @(posedge clk) begin
    case (state)
      wave_pkg::BK_IDLE: begin
        neg     <= turn_sum[wave_pkg::VEL_W-1] ^ direction_inverted;
        mag     <= turn_sum[wave_pkg::VEL_W-1] ? wave_pkg::VEL_W'(-turn_sum)
                                                : wave_pkg::VEL_W'(turn_sum);
        elapsed <= elapsed_c;
        res_status <= wave_pkg::STATUS_ZERO;
        if (turn_sum == '0) begin
          res_vel <= '0;
        end else if (turn_sum[wave_pkg::VEL_W-1] ^ direction_inverted) begin
          res_vel <= wave_pkg::VEL_MIN;
        end else begin
          res_vel <= wave_pkg::VEL_MAX;
        end
      end
      wave_pkg::BK_MUL: begin
        quo <= wave_pkg::PROD_W'(mag) * wave_pkg::PROD_W'(wave_pkg::US_PER_S);
        rem <= '0;
        cnt <= '0;
      end
      wave_pkg::BK_DIV: begin
        rem <= trial_ge ? wave_pkg::TIME_W'(trial - {1'b0, elapsed})
                        : trial[wave_pkg::TIME_W-1:0];
        quo <= {quo[wave_pkg::PROD_W-2:0], trial_ge};
        cnt <= cnt + CntW'(1);
      end
      wave_pkg::BK_FIN: begin
        if (!neg) begin
          if (quo > wave_pkg::PROD_W'(wave_pkg::VEL_MAX)) begin
            res_vel    <= wave_pkg::VEL_MAX;
            res_status <= wave_pkg::STATUS_SAT;
          end else begin
            res_vel    <= $signed(quo[wave_pkg::VEL_W-1:0]);
            res_status <= wave_pkg::STATUS_OK;
          end
        end else begin
          if (quo > (wave_pkg::PROD_W'(1) << (wave_pkg::VEL_W - 1))) begin
            res_vel    <= wave_pkg::VEL_MIN;
            res_status <= wave_pkg::STATUS_SAT;
          end else begin
            res_vel    <= -$signed(quo[wave_pkg::VEL_W-1:0]);
            res_status <= wave_pkg::STATUS_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while new words are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == wave_pkg::BK_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wave_pkg::BK_OUT && out_free) begin
      out_vel    <= res_vel;
      out_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_status, out_vel};

endmodule

@@ test/tb_wheel_angle_velocity_estimator.sv @@
// Testbench for the wheel angle velocity estimator: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_wheel_angle_velocity_estimator;

  localparam int FULL_TURN = 1 << wave_pkg::ANGLE_FIELD_W;
  localparam int HALF_TURN = FULL_TURN / 2;
  localparam longint MICROS_PER_SEC = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic signed [wave_pkg::VEL_W-1:0] velocity;
    wave_pkg::status_t                 status;
  } velocity_word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  // [9:0] angle_sample, [41:10] now_us, [47:42] zero
  logic [wave_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  // [0] action
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // [31:0] velocity, [33:32] status, [39:34] zero
  logic [wave_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_data = 1'b0;

  // Predicted state of the estimator.
  logic [wave_pkg::ANGLE_FIELD_W-1:0] est_last_angle = '0;
  logic signed [wave_pkg::VEL_W-1:0]  est_turn_sum = '0;
  logic [wave_pkg::TIME_W-1:0]        est_last_time = '0;
  logic                               est_inverted = 1'b0;
  velocity_word_t                     velocity_due[$];

  // Sender-side view of the wheel and the clock it reports.
  logic [wave_pkg::ANGLE_FIELD_W-1:0] walk_angle = '0;
  logic [wave_pkg::TIME_W-1:0]        walk_time = '0;

  bit steady = 1'b0;
  bit stall_request = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int idle_cycles = 0;

  wheel_angle_velocity_estimator #(.ANGLE_BITS(wave_pkg::ANGLE_FIELD_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s at %0t: got %0d, want %0d", what, $realtime, got, want);
    errors++;
  endtask

  task automatic advance_estimate(input wave_pkg::item_kind_t kind,
                                  input logic [wave_pkg::ANGLE_FIELD_W-1:0] angle,
                                  input logic [wave_pkg::TIME_W-1:0] now);
    int diff;
    int step;
    longint sum;
    longint v;
    logic [wave_pkg::TIME_W-1:0] elapsed;
    velocity_word_t w;
    if (kind == wave_pkg::KIND_SAMPLE) begin
      diff = int'(angle) - int'(est_last_angle);
      if (diff > HALF_TURN) step = FULL_TURN - diff;
      else if (diff < -HALF_TURN) step = -FULL_TURN - diff;
      else step = -diff;
      sum = longint'(est_turn_sum) + step;
      if (sum > longint'(wave_pkg::VEL_MAX)) sum = longint'(wave_pkg::VEL_MAX);
      else if (sum < longint'(wave_pkg::VEL_MIN)) sum = longint'(wave_pkg::VEL_MIN);
      est_turn_sum = sum[wave_pkg::VEL_W-1:0];
      est_last_angle = angle;
    end else begin
      elapsed = now - est_last_time;
      w.status = wave_pkg::STATUS_OK;
      if (elapsed == '0) begin
        // One past the limit on either side, so that it clamps after any inversion.
        if (est_turn_sum > 0) v = longint'(wave_pkg::VEL_MAX) + 1;
        else if (est_turn_sum < 0) v = longint'(wave_pkg::VEL_MIN) - 1;
        else v = 0;
        w.status = wave_pkg::STATUS_ZERO;
      end else begin
        v = (longint'(est_turn_sum) * MICROS_PER_SEC) / longint'({32'd0, elapsed});
      end
      if (est_inverted) v = -v;
      if (v > longint'(wave_pkg::VEL_MAX)) begin
        v = longint'(wave_pkg::VEL_MAX);
        if (w.status == wave_pkg::STATUS_OK) w.status = wave_pkg::STATUS_SAT;
      end else if (v < longint'(wave_pkg::VEL_MIN)) begin
        v = longint'(wave_pkg::VEL_MIN);
        if (w.status == wave_pkg::STATUS_OK) w.status = wave_pkg::STATUS_SAT;
      end
      w.velocity = v[wave_pkg::VEL_W-1:0];
      velocity_due.push_back(w);
      est_turn_sum = '0;
      est_last_time = now;
    end
  endtask

  // Inputs are sampled before the edge updates them, so the handshakes seen here are exact.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) est_inverted = cfg_data;
      if (s_tvalid && s_tready)
        advance_estimate(wave_pkg::item_kind_t'(s_tuser),
                         s_tdata[wave_pkg::ANGLE_FIELD_W-1:0],
                         s_tdata[wave_pkg::ANGLE_FIELD_W +: wave_pkg::TIME_W]);
    end
  end

  always @(posedge clk) begin : check_output
    velocity_word_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (velocity_due.size() == 0) begin
        report_mismatch("unexpected word velocity",
                        longint'($signed(m_tdata[wave_pkg::VEL_W-1:0])), 0);
      end else begin
        due = velocity_due.pop_front();
        if (m_tdata[wave_pkg::VEL_W-1:0] !== due.velocity)
          report_mismatch("velocity", longint'($signed(m_tdata[wave_pkg::VEL_W-1:0])),
                          longint'(due.velocity));
        if (m_tdata[wave_pkg::VEL_W +: wave_pkg::STATUS_W] !== due.status)
          report_mismatch("status", longint'(m_tdata[wave_pkg::VEL_W +: wave_pkg::STATUS_W]),
                          longint'(due.status));
      end
    end
  end

  // Receiver: random stalls, none in a steady stretch, and one long hold-off on request.
  always @(posedge clk) begin
    if (stall_request) begin
      hold_left = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[wheel_angle_velocity_estimator] ERROR");
        $finish;
      end
    end
  end

  // Offers one word and returns at the edge that accepts it. Ready is sampled on the
  // falling edge, when every input set at the rising edge has settled.
  task automatic send_word(input wave_pkg::item_kind_t kind,
                           input logic [wave_pkg::ANGLE_FIELD_W-1:0] angle,
                           input logic [wave_pkg::TIME_W-1:0] now);
    logic ready_seen;
    if (!steady && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'd0, now, angle};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic send_sample(input logic [wave_pkg::ANGLE_FIELD_W-1:0] angle);
    walk_angle = angle;
    send_word(wave_pkg::KIND_SAMPLE, angle, $urandom());
  endtask

  task automatic send_query(input logic [wave_pkg::TIME_W-1:0] now);
    walk_time = now;
    send_word(wave_pkg::KIND_QUERY,
              wave_pkg::ANGLE_FIELD_W'($urandom_range(0, FULL_TURN - 1)), now);
  endtask

  // Drains the block, lets queued samples finish, then writes the inversion register.
  task automatic set_inversion(input logic value);
    logic ready_seen;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (velocity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_angle_steps();
    set_inversion(1'b0);
    // Query at the reset time with nothing summed.
    send_query(32'd0);
    // Exactly half a turn either way, the largest jumps, and just past half a turn.
    send_sample(10'd512);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd513);
    send_sample(10'd0);
    send_sample(10'd300);
    send_query(32'd1000);
    send_query(32'hFFFF_FFFF);
    // Crossing zero downward, then a query after the time counter wraps.
    send_sample(10'd1023);
    send_query(32'h0000_0010);
  endtask

  task automatic test_zero_elapsed();
    send_sample(walk_angle + 10'd5);
    send_query(walk_time);
    send_sample(walk_angle - 10'd5);
    send_query(walk_time);
    set_inversion(1'b1);
    send_sample(walk_angle - 10'd7);
    send_query(walk_time);
  endtask

  task automatic test_saturation();
    set_inversion(1'b0);
    repeat (5) send_sample(walk_angle + 10'd512);
    send_query(walk_time + 32'd1);
    set_inversion(1'b1);
    repeat (5) send_sample(walk_angle + 10'd511);
    send_query(walk_time + 32'd1);
  endtask

  // Runs of samples walking the wheel one way, each mostly closed by a query.
  task automatic random_runs(input int count);
    int sent;
    int run_len;
    int run_max;
    int mag;
    int queries;
    int sel;
    bit forward;
    logic [wave_pkg::TIME_W-1:0] gap;
    sent = 0;
    while (sent < count) begin
      run_len = $urandom_range(1, 12);
      forward = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 2);
      run_max = (sel == 0) ? 3 : (sel == 1) ? 64 : HALF_TURN;
      repeat (run_len) begin
        mag = $urandom_range(0, run_max);
        if ($urandom_range(0, 99) < 15)
          send_sample(wave_pkg::ANGLE_FIELD_W'($urandom_range(0, FULL_TURN - 1)));
        else if (forward)
          send_sample(walk_angle + wave_pkg::ANGLE_FIELD_W'(mag));
        else
          send_sample(walk_angle - wave_pkg::ANGLE_FIELD_W'(mag));
        sent++;
      end
      // Some runs carry their sum on into the next run.
      queries = ($urandom_range(0, 99) < 20) ? 0 : ($urandom_range(0, 9) == 0) ? 2 : 1;
      repeat (queries) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) gap = '0;
        else if (sel < 35) gap = $urandom_range(1, 16);
        else if (sel < 65) gap = $urandom_range(17, 100000);
        else if (sel < 85) gap = $urandom_range(100001, 50000000);
        else gap = $urandom();
        send_query(walk_time + gap);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    set_inversion(1'b1);
    random_runs(100);
    set_inversion(1'b0);
    steady = 1'b1;
    random_runs(100);
    steady = 1'b0;
    set_inversion(1'b1);
    random_runs(100);
    set_inversion(1'b0);
    random_runs(100);
  endtask

  // The receiver holds off while queries keep coming, so the result register and the
  // input queue fill and the input stalls.
  task automatic test_backpressure();
    steady = 1'b1;
    stall_request = 1'b1;
    repeat (8) begin
      repeat (3)
        send_sample(walk_angle + wave_pkg::ANGLE_FIELD_W'($urandom_range(0, HALF_TURN)));
      send_query(walk_time + $urandom_range(1, 5000));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_angle_steps();
    test_zero_elapsed();
    test_saturation();
    test_random();
    test_backpressure();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (velocity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 36) @(posedge clk);
    if (errors == 0) begin
      $display("[wheel_angle_velocity_estimator] OK");
    end else begin
      $display("[wheel_angle_velocity_estimator] ERROR");
    end
    $finish;
  end

endmodule

@@ wheel_angle_velocity_estimator.f @@
sv/wave_pkg.sv
sv/wave_front.sv
sv/wave_back.sv
sv/wheel_angle_velocity_estimator.sv
test/tb_wheel_angle_velocity_estimator.sv
